// ----- hdl/task_slot_state_table_defines.svh -----
// Assertion macros shared by the task slot state table RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef TASK_SLOT_STATE_TABLE_DEFINES_SVH
`define TASK_SLOT_STATE_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication, checked out of reset.
`define TSST_ASSERT_LATER2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ----- hdl/tsst_pkg.sv -----
// Types, codes and the legality matrix of the task slot state table.
// Used by every module of the block; no dependencies.
package tsst_pkg;

    localparam int SLOT_W     = 6;
    localparam int SLOT_SPACE = 64;
    localparam int STATE_W    = 3;
    localparam int GEN_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 7;

    localparam int SLOT_COUNT_DEFAULT = 64;
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 7'd64;

    localparam logic [STATE_W-1:0] NUM_STATES = 3'd6;

    typedef enum logic [STATE_W-1:0] {
        ST_FREE    = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_ZOMBIE  = 3'd3,
        ST_BLOCKED = 3'd4,
        ST_SETUP   = 3'd5
    } lifecycle_t;

    typedef enum logic {
        ACT_TRANSITION = 1'b0,
        ACT_VALIDATE   = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_OUT_OF_RANGE = 3'd1,
        STS_ILLEGAL      = 3'd2,
        STS_MISMATCH     = 3'd3,
        STS_SLOT_FREE    = 3'd4
    } status_t;

    // Row is the present state, bit position the requested state.
    localparam logic [5:0] LEGAL_MOVE [6] = '{
        6'b100000,
        6'b011100,
        6'b011010,
        6'b000001,
        6'b001010,
        6'b000111
    };

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [GEN_W-1:0]   gen;
    } entry_t;

    typedef struct packed {
        logic               action;
        logic [SLOT_W-1:0]  slot;
        logic [STATE_W-1:0] target;
        logic [GEN_W-1:0]   ref_gen;
    } req_t;

    typedef struct packed {
        logic    accepted;
        status_t status;
        entry_t  next;
        entry_t  shown;
        logic    wr_en;
        logic    bump_illegal;
        logic    bump_mismatch;
    } upd_t;

    function automatic logic legal_move(logic [STATE_W-1:0] from_st,
                                        logic [STATE_W-1:0] to_st);
        logic ok;
        ok = 1'b0;
        if (from_st < NUM_STATES && to_st < NUM_STATES)
        begin
            ok = LEGAL_MOVE[from_st][to_st];
        end
        return ok;
    endfunction

endpackage

// ----- hdl/task_slot_state_table.sv -----
// Task slot state table: top level with request pipeline, forwarding and counters.
// Depends on tsst_pkg, tsst_slot_mem, tsst_update and the assertion macro header.
//
// Usage:
//   Requests arrive on start with action, slot, target_state and ref_generation.
//   A request is taken at every clock edge where start is high and busy is low;
//   busy stays low, so one request can be taken every cycle.
//   Each request gives one result through the request and result registers: done pulses for
//   one cycle with accepted, status, slot_state, slot_generation, illegal_count
//   and mismatch_count. Results must be taken in that cycle; there is no stall.
//   Throughput is one request per cycle. The result passes through the slot memory's
//   registered read port and the result register.
//   Back-to-back requests to the same slot see the preceding write through a
//   one-entry forwarding register on the memory read path.
//   slots_in_use is written on the cfg channel (cfg_valid, cfg_ready, cfg_data); the user must
//   write it only while no request is in flight, the block does not enforce this; cfg_ready is always high.
//   Reset clears all slots to free with generation zero, both counters to zero
//   and slots_in_use to 64. No clearing pass is needed: requests are taken from
//   the first cycle after reset.
module task_slot_state_table #(
    parameter int SLOT_COUNT = tsst_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [tsst_pkg::SLOT_W-1:0]   slot,
    input  logic [tsst_pkg::STATE_W-1:0]  target_state,
    input  logic [tsst_pkg::GEN_W-1:0]    ref_generation,
    output logic                          done,
    output logic                          accepted,
    output logic [2:0]                    status,
    output logic [tsst_pkg::STATE_W-1:0]  slot_state,
    output logic [tsst_pkg::GEN_W-1:0]    slot_generation,
    output logic [tsst_pkg::CNT_W-1:0]    illegal_count,
    output logic [tsst_pkg::CNT_W-1:0]    mismatch_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsst_pkg::CFG_W-1:0]    cfg_data
);
    import tsst_pkg::*;

    `include "task_slot_state_table_defines.svh"

    localparam int DEPTH  = (SLOT_COUNT < SLOT_SPACE) ? SLOT_COUNT : SLOT_SPACE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W  = $clog2(SLOT_COUNT + 1);
    localparam int LIM_W  = (CAP_W > CFG_W) ? CAP_W : CFG_W;
    localparam logic [LIM_W-1:0] SLOT_CAP = LIM_W'(SLOT_COUNT);

    logic               accept;
    req_t               in_req;
    logic [CFG_W-1:0]   slots_in_use_reg;

    logic               s1_valid_reg;
    req_t               s1_req_reg;
    logic [ADDR_W-1:0]  s1_addr;
    logic               s1_in_range;
    logic [LIM_W-1:0]   s1_slot_ext;
    logic [LIM_W-1:0]   use_ext;

    entry_t             mem_rd;
    entry_t             cur;
    upd_t               upd;
    logic               wr_en;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    entry_t             fwd_data_reg;

    logic               done_reg;
    logic               accepted_reg;
    status_t            status_reg;
    entry_t             shown_reg;
    logic [CNT_W-1:0]   illegal_cnt_reg;
    logic [CNT_W-1:0]   illegal_cnt_next;
    logic [CNT_W-1:0]   mismatch_cnt_reg;
    logic [CNT_W-1:0]   mismatch_cnt_next;

    // The table takes a request every cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign in_req.action  = action;
    assign in_req.slot    = slot;
    assign in_req.target  = target_state;
    assign in_req.ref_gen = ref_generation;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slots_in_use_reg <= cfg_data;
        end
    end

    tsst_slot_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (slot[ADDR_W-1:0]),
        .rd_data (mem_rd),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (upd.next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= in_req;
        end
        fwd_addr_reg <= s1_addr;
        fwd_data_reg <= upd.next;
    end

    assign s1_addr     = s1_req_reg.slot[ADDR_W-1:0];
    assign s1_slot_ext = LIM_W'(s1_req_reg.slot);
    assign use_ext     = LIM_W'(slots_in_use_reg);
    assign s1_in_range = (s1_slot_ext < use_ext) && (s1_slot_ext < SLOT_CAP);

    // Take the entry written last cycle; the memory read missed it.
    assign cur = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : mem_rd;

    tsst_update u_update (
        .req      (s1_req_reg),
        .in_range (s1_in_range),
        .cur      (cur),
        .upd      (upd)
    );

    assign wr_en = s1_valid_reg && upd.wr_en;

    always_comb
    begin
        illegal_cnt_next  = illegal_cnt_reg;
        mismatch_cnt_next = mismatch_cnt_reg;
        if (s1_valid_reg && upd.bump_illegal)
        begin
            illegal_cnt_next = illegal_cnt_reg + 1'b1;
        end
        if (s1_valid_reg && upd.bump_mismatch)
        begin
            mismatch_cnt_next = mismatch_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            illegal_cnt_reg  <= '0;
            mismatch_cnt_reg <= '0;
        end
        else
        begin
            done_reg         <= s1_valid_reg;
            illegal_cnt_reg  <= illegal_cnt_next;
            mismatch_cnt_reg <= mismatch_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            accepted_reg <= upd.accepted;
            status_reg   <= upd.status;
            shown_reg    <= upd.shown;
        end
    end

    assign done            = done_reg;
    assign accepted        = accepted_reg;
    assign status          = status_reg;
    assign slot_state      = shown_reg.state;
    assign slot_generation = shown_reg.gen;
    assign illegal_count   = illegal_cnt_reg;
    assign mismatch_count  = mismatch_cnt_reg;

    `TSST_ASSERT_LATER2(a_result_follows, clk, rst_n, accept, done_reg,
        "result strobe missing two cycles after request transfer")
    `TSST_ASSERT_NOW(a_out_of_range_blank, clk, rst_n,
        done_reg && status_reg == STS_OUT_OF_RANGE,
        !accepted_reg && shown_reg == '0, "out-of-range result not blank")
    `TSST_ASSERT_NOW(a_accept_is_ok, clk, rst_n, done_reg && accepted_reg,
        status_reg == STS_OK, "accepted result carries non-ok status")
    `TSST_ASSERT_NOW(a_illegal_cnt_moves, clk, rst_n,
        illegal_cnt_reg != $past(illegal_cnt_reg),
        done_reg && status_reg == STS_ILLEGAL, "illegal count moved without illegal result")
    `TSST_ASSERT_NOW(a_mismatch_cnt_moves, clk, rst_n,
        mismatch_cnt_reg != $past(mismatch_cnt_reg),
        done_reg && status_reg == STS_MISMATCH, "mismatch count moved without mismatch result")

endmodule

// ----- hdl/tsst_slot_mem.sv -----
// Slot memory: one entry (state, generation) per slot, registered read port.
// Per-entry valid flags make unwritten entries read as free with generation zero.
module tsst_slot_mem #(
    parameter int DEPTH  = tsst_pkg::SLOT_SPACE,
    parameter int ADDR_W = tsst_pkg::SLOT_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output tsst_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  tsst_pkg::entry_t      wr_data
);
    import tsst_pkg::*;

    entry_t           mem [DEPTH];
    entry_t           rd_data_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as their reset value: free, generation zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hdl/tsst_update.sv -----
// Request evaluation: legality check, generation advance and reference check.
// Depends on tsst_pkg for the entry, request and update types.
module tsst_update (
    input  tsst_pkg::req_t    req,
    input  logic              in_range,
    input  tsst_pkg::entry_t  cur,
    output tsst_pkg::upd_t    upd
);
    import tsst_pkg::*;

    always_comb
    begin
        upd               = '0;
        upd.status        = STS_OUT_OF_RANGE;
        upd.next          = cur;
        if (in_range)
        begin
            case (req.action)
                ACT_TRANSITION:
                begin
                    if (legal_move(cur.state, req.target))
                    begin
                        upd.next.state = req.target;
                        // Only a fresh tenancy advances the generation.
                        if (cur.state == ST_FREE && req.target == ST_SETUP)
                        begin
                            upd.next.gen = cur.gen + 1'b1;
                        end
                        upd.wr_en    = 1'b1;
                        upd.accepted = 1'b1;
                        upd.status   = STS_OK;
                    end
                    else
                    begin
                        upd.bump_illegal = 1'b1;
                        upd.status       = STS_ILLEGAL;
                    end
                end
                ACT_VALIDATE:
                begin
                    // Mismatch is checked before the free slot.
                    if (cur.gen != req.ref_gen)
                    begin
                        upd.bump_mismatch = 1'b1;
                        upd.status        = STS_MISMATCH;
                    end
                    else if (cur.state == ST_FREE)
                    begin
                        upd.status = STS_SLOT_FREE;
                    end
                    else
                    begin
                        upd.accepted = 1'b1;
                        upd.status   = STS_OK;
                    end
                end
                default:
                begin
                    upd.status = STS_OUT_OF_RANGE;
                end
            endcase
            upd.shown = upd.next;
        end
        else
        begin
            upd.shown = '0;
        end
    end

endmodule
